// ----- rtl/tvn_pkg.sv -----
// tvn_pkg: shared types and constants for the triangle vertex normal block.
// No dependencies; compiled first.
package tvn_pkg;

    // significant bits kept by the block-floating step before the length
    localparam int NORM_BITS = 30;
    // width of one Q1.14 normal component on the result channel
    localparam int OUT_BITS = 16;
    // index of the last vertex of a triangle
    localparam logic [1:0] LAST_VERTEX = 2'd2;

    // head-of-queue status seen by the back end
    typedef struct packed {
        logic valid;
        logic smooth;
    } tvn_job_t;

endpackage

// ----- rtl/tvn_if.sv -----
// tvn_if: valid/ready channel interfaces for triangles in and normals out.
// Depends on tvn_pkg for the result widths.
interface tvn_tri_if #(parameter int COORD_BITS = 24);
    logic valid;
    logic ready;
    logic signed [COORD_BITS-1:0] ax;
    logic signed [COORD_BITS-1:0] ay;
    logic signed [COORD_BITS-1:0] az;
    logic signed [COORD_BITS-1:0] bx;
    logic signed [COORD_BITS-1:0] by_coord;
    logic signed [COORD_BITS-1:0] bz;
    logic signed [COORD_BITS-1:0] cx;
    logic signed [COORD_BITS-1:0] cy;
    logic signed [COORD_BITS-1:0] cz;

    modport source (output valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz, input ready);
    modport sink (input valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz, output ready);
endinterface

interface tvn_nrm_if;
    logic valid;
    logic ready;
    logic [1:0] vertex_index;
    logic signed [tvn_pkg::OUT_BITS-1:0] nx;
    logic signed [tvn_pkg::OUT_BITS-1:0] ny;
    logic signed [tvn_pkg::OUT_BITS-1:0] nz;
    logic degenerate;
    logic last;

    modport source (output valid, vertex_index, nx, ny, nz, degenerate, last, input ready);
    modport sink (input valid, vertex_index, nx, ny, nz, degenerate, last, output ready);
endinterface

// ----- rtl/tvn_front.sv -----
// tvn_front: accepts triangles, tags each with the current mode and queues them (2 deep).
// Depends on tvn_pkg and tvn_tri_if.
module tvn_front #(
    parameter int COORD_BITS = 24
) (
    input  logic                         clk,
    input  logic                         rst_n,
    tvn_tri_if.sink                      tri_in,
    input  logic                         cfg_we,
    input  logic                         cfg_wdata,
    output logic signed [COORD_BITS-1:0] job_crd [9],
    output tvn_pkg::tvn_job_t            job,
    input  logic                         job_take
);

    logic signed [COORD_BITS-1:0] crd_mem_reg [2][9];
    logic                         mode_mem_reg [2];
    logic                         wr_ptr_reg, rd_ptr_reg;
    logic [1:0]                   cnt_reg;
    logic                         smooth_reg;
    logic                         push, pop;

    assign tri_in.ready = (cnt_reg != 2'd2);
    assign push = tri_in.valid && tri_in.ready;
    assign pop  = job_take && (cnt_reg != 2'd0);

    assign job.valid  = (cnt_reg != 2'd0);
    assign job.smooth = mode_mem_reg[rd_ptr_reg];
    assign job_crd    = crd_mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
            smooth_reg <= 1'b1;
        end
        else
        begin
            if (cfg_we)
            begin
                smooth_reg <= cfg_wdata;
            end
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    // queue storage: payload only
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            crd_mem_reg[wr_ptr_reg][0] <= tri_in.ax;
            crd_mem_reg[wr_ptr_reg][1] <= tri_in.ay;
            crd_mem_reg[wr_ptr_reg][2] <= tri_in.az;
            crd_mem_reg[wr_ptr_reg][3] <= tri_in.bx;
            crd_mem_reg[wr_ptr_reg][4] <= tri_in.by_coord;
            crd_mem_reg[wr_ptr_reg][5] <= tri_in.bz;
            crd_mem_reg[wr_ptr_reg][6] <= tri_in.cx;
            crd_mem_reg[wr_ptr_reg][7] <= tri_in.cy;
            crd_mem_reg[wr_ptr_reg][8] <= tri_in.cz;
            mode_mem_reg[wr_ptr_reg]   <= smooth_reg;
        end
    end

endmodule

// ----- rtl/tvn_div.sv -----
// tvn_div: one lane of restoring division, one quotient bit per cycle while step is high.
// No dependencies.
module tvn_div #(
    parameter int QB   = 15,
    parameter int NUMW = 45
) (
    input  logic            clk,
    input  logic            start,
    input  logic            step,
    input  logic [NUMW-1:0] num,
    input  logic [30:0]     den,
    output logic [QB-1:0]   quo
);

    logic [31:0]   rem_reg;
    logic [QB-1:0] lo_reg;
    logic [QB-1:0] q_reg;
    logic [31:0]   rem_sh;
    logic          ge;

    assign rem_sh = {rem_reg[30:0], lo_reg[QB-1]};
    assign ge     = rem_sh >= {1'b0, den};
    assign quo    = q_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            // upper part is always below the divisor, so QB steps suffice
            rem_reg <= 32'(num[NUMW-1:QB]);
            lo_reg  <= num[QB-1:0];
            q_reg   <= '0;
        end
        else if (step)
        begin
            rem_reg <= ge ? (rem_sh - {1'b0, den}) : rem_sh;
            lo_reg  <= {lo_reg[QB-2:0], 1'b0};
            q_reg   <= {q_reg[QB-2:0], ge};
        end
    end

endmodule

// ----- rtl/tvn_back.sv -----
// tvn_back: cross product or vertex load, block-floating step, square root, division and result beats.
// Depends on tvn_pkg, tvn_nrm_if and tvn_div.
module tvn_back #(
    parameter int COORD_BITS       = 24,
    parameter int NORMAL_FRAC_BITS = 14
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic signed [COORD_BITS-1:0] job_crd [9],
    input  tvn_pkg::tvn_job_t            job,
    output logic                         job_take,
    tvn_nrm_if.source                    nrm_out
);

    localparam int EW   = COORD_BITS + 1;
    localparam int PW   = 2 * COORD_BITS + 2;
    localparam int NB   = tvn_pkg::NORM_BITS;
    localparam int SW   = (PW > NB) ? PW : NB;
    localparam int QB   = NORMAL_FRAC_BITS + 1;
    localparam int NUMW = NB + NORMAL_FRAC_BITS + 1;
    localparam int OB   = tvn_pkg::OUT_BITS;

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_MUL, S_MAG, S_NORM, S_SQR, S_ROOT, S_DGO, S_DIV, S_SAT, S_EMIT
    } state_t;

    state_t                state_reg;
    logic [1:0]            idx_reg;
    logic                  mode_reg;
    logic [4:0]            step_reg;
    logic signed [EW-1:0]  e1_reg [3];
    logic signed [EW-1:0]  e2_reg [3];
    logic signed [PW-1:0]  prod_reg;
    logic signed [PW-1:0]  acc_reg [3];
    logic [SW-1:0]         mag_reg [3];
    logic                  neg_reg [3];
    logic [59:0]           sqp_reg;
    logic [61:0]           sum_reg;
    logic [31:0]           rem_reg;
    logic [30:0]           root_reg;
    logic signed [OB-1:0]  nrm_reg [3];
    logic                  deg_reg;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [1:0]            out_idx_reg;
    logic signed [OB-1:0]  out_nx_reg, out_ny_reg, out_nz_reg;
    logic                  out_deg_reg;

    logic signed [EW-1:0]  mul_a, mul_b;
    logic signed [PW-1:0]  mul_p;
    logic [2:0]            pidx;
    logic [SW-1:0]         or_v;
    logic [29:0]           sq_op;
    logic [33:0]           rem_sh, trial;
    logic                  root_ge;
    logic signed [COORD_BITS-1:0] ld_c [3];
    logic                  can_emit;
    logic                  emit;
    logic                  div_start, div_step;
    logic [QB-1:0]         quo [3];

    function automatic logic signed [OB-1:0] sat_nrm(input logic [QB-1:0] q, input logic neg);
        logic [31:0] qe;
        logic [31:0] lim;
        qe = 32'(q);
        if (neg)
        begin
            lim = (qe > 32'd32768) ? 32'd32768 : qe;
            return OB'(32'd0 - lim);
        end
        lim = (qe > 32'd32767) ? 32'd32767 : qe;
        return OB'(lim);
    endfunction

    // cross-product term operands: even steps add, odd steps subtract
    always_comb
    begin
        case (step_reg[2:0])
            3'd0:    begin mul_a = e1_reg[1]; mul_b = e2_reg[2]; end
            3'd1:    begin mul_a = e1_reg[2]; mul_b = e2_reg[1]; end
            3'd2:    begin mul_a = e1_reg[2]; mul_b = e2_reg[0]; end
            3'd3:    begin mul_a = e1_reg[0]; mul_b = e2_reg[2]; end
            3'd4:    begin mul_a = e1_reg[0]; mul_b = e2_reg[1]; end
            default: begin mul_a = e1_reg[1]; mul_b = e2_reg[0]; end
        endcase
    end
    assign mul_p = mul_a * mul_b;
    assign pidx  = step_reg[2:0] - 3'd1;

    assign or_v = mag_reg[0] | mag_reg[1] | mag_reg[2];

    always_comb
    begin
        case (step_reg[1:0])
            2'd0:    sq_op = mag_reg[0][29:0];
            2'd1:    sq_op = mag_reg[1][29:0];
            default: sq_op = mag_reg[2][29:0];
        endcase
    end

    assign rem_sh  = {rem_reg, sum_reg[61:60]};
    assign trial   = {1'b0, root_reg, 2'b01};
    assign root_ge = rem_sh >= trial;

    always_comb
    begin
        case (idx_reg)
            2'd0:    begin ld_c[0] = job_crd[0]; ld_c[1] = job_crd[1]; ld_c[2] = job_crd[2]; end
            2'd1:    begin ld_c[0] = job_crd[3]; ld_c[1] = job_crd[4]; ld_c[2] = job_crd[5]; end
            default: begin ld_c[0] = job_crd[6]; ld_c[1] = job_crd[7]; ld_c[2] = job_crd[8]; end
        endcase
    end

    assign can_emit       = !out_valid_reg || nrm_out.ready;
    assign emit           = (state_reg == S_EMIT) && can_emit;
    assign out_valid_next = emit || (out_valid_reg && !nrm_out.ready);
    assign job_take       = emit && (idx_reg == tvn_pkg::LAST_VERTEX);
    assign div_start      = (state_reg == S_DGO);
    assign div_step       = (state_reg == S_DIV);

    for (genvar g = 0; g < 3; g++)
    begin : g_div
        tvn_div #(.QB(QB), .NUMW(NUMW)) u_div (
            .clk   (clk),
            .start (div_start),
            .step  (div_step),
            .num   ((NUMW'(mag_reg[g][29:0]) << NORMAL_FRAC_BITS) + NUMW'(root_reg[30:1])),
            .den   (root_reg),
            .quo   (quo[g])
        );
    end

    assign nrm_out.valid        = out_valid_reg;
    assign nrm_out.vertex_index = out_idx_reg;
    assign nrm_out.nx           = out_nx_reg;
    assign nrm_out.ny           = out_ny_reg;
    assign nrm_out.nz           = out_nz_reg;
    assign nrm_out.degenerate   = out_deg_reg;
    assign nrm_out.last         = (out_idx_reg == tvn_pkg::LAST_VERTEX);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= 2'd0;
            mode_reg      <= 1'b1;
            step_reg      <= 5'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (job.valid)
                    begin
                        mode_reg <= job.smooth;
                        idx_reg  <= 2'd0;
                        step_reg <= 5'd0;
                        for (int j = 0; j < 3; j++)
                        begin
                            e1_reg[j]  <= EW'(job_crd[j]) - EW'(job_crd[j+3]);
                            e2_reg[j]  <= EW'(job_crd[j+3]) - EW'(job_crd[j+6]);
                            acc_reg[j] <= '0;
                        end
                        state_reg <= job.smooth ? S_LOAD : S_MUL;
                    end
                end
                S_LOAD:
                begin
                    for (int j = 0; j < 3; j++)
                    begin
                        neg_reg[j] <= ld_c[j][COORD_BITS-1];
                        mag_reg[j] <= SW'($unsigned(ld_c[j][COORD_BITS-1] ?
                                      -EW'(ld_c[j]) : EW'(ld_c[j])));
                    end
                    state_reg <= S_NORM;
                end
                S_MUL:
                begin
                    prod_reg <= mul_p;
                    if (step_reg != 5'd0)
                    begin
                        if (pidx[0])
                            acc_reg[pidx[2:1]] <= acc_reg[pidx[2:1]] - prod_reg;
                        else
                            acc_reg[pidx[2:1]] <= acc_reg[pidx[2:1]] + prod_reg;
                    end
                    step_reg <= step_reg + 5'd1;
                    if (step_reg == 5'd6)
                    begin
                        state_reg <= S_MAG;
                    end
                end
                S_MAG:
                begin
                    for (int j = 0; j < 3; j++)
                    begin
                        neg_reg[j] <= acc_reg[j][PW-1];
                        mag_reg[j] <= SW'($unsigned(acc_reg[j][PW-1] ? -acc_reg[j] : acc_reg[j]));
                    end
                    state_reg <= S_NORM;
                end
                S_NORM:
                begin
                    // walk the common exponent until the top set bit is bit 29
                    if (or_v == '0)
                    begin
                        deg_reg   <= 1'b1;
                        for (int j = 0; j < 3; j++)
                            nrm_reg[j] <= '0;
                        state_reg <= S_EMIT;
                    end
                    else if ((or_v >> 34) != '0)
                    begin
                        for (int j = 0; j < 3; j++)
                            mag_reg[j] <= mag_reg[j] >> 4;
                    end
                    else if ((or_v >> 30) != '0)
                    begin
                        for (int j = 0; j < 3; j++)
                            mag_reg[j] <= mag_reg[j] >> 1;
                    end
                    else if (or_v[29:26] == 4'd0)
                    begin
                        for (int j = 0; j < 3; j++)
                            mag_reg[j] <= mag_reg[j] << 4;
                    end
                    else if (!or_v[29])
                    begin
                        for (int j = 0; j < 3; j++)
                            mag_reg[j] <= mag_reg[j] << 1;
                    end
                    else
                    begin
                        deg_reg   <= 1'b0;
                        step_reg  <= 5'd0;
                        sum_reg   <= '0;
                        state_reg <= S_SQR;
                    end
                end
                S_SQR:
                begin
                    sqp_reg <= sq_op * sq_op;
                    if (step_reg != 5'd0)
                    begin
                        sum_reg <= sum_reg + 62'(sqp_reg);
                    end
                    if (step_reg == 5'd3)
                    begin
                        step_reg  <= 5'd0;
                        rem_reg   <= '0;
                        root_reg  <= '0;
                        state_reg <= S_ROOT;
                    end
                    else
                    begin
                        step_reg <= step_reg + 5'd1;
                    end
                end
                S_ROOT:
                begin
                    rem_reg  <= root_ge ? 32'(rem_sh - trial) : rem_sh[31:0];
                    root_reg <= {root_reg[29:0], root_ge};
                    sum_reg  <= {sum_reg[59:0], 2'b00};
                    step_reg <= step_reg + 5'd1;
                    if (step_reg == 5'd30)
                    begin
                        state_reg <= S_DGO;
                    end
                end
                S_DGO:
                begin
                    step_reg  <= 5'd0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    step_reg <= step_reg + 5'd1;
                    if (step_reg == 5'(QB - 1))
                    begin
                        state_reg <= S_SAT;
                    end
                end
                S_SAT:
                begin
                    for (int j = 0; j < 3; j++)
                        nrm_reg[j] <= sat_nrm(quo[j], neg_reg[j]);
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (can_emit)
                    begin
                        out_idx_reg   <= idx_reg;
                        out_nx_reg    <= nrm_reg[0];
                        out_ny_reg    <= nrm_reg[1];
                        out_nz_reg    <= nrm_reg[2];
                        out_deg_reg   <= deg_reg;
                        if (idx_reg == tvn_pkg::LAST_VERTEX)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 2'd1;
                            state_reg <= mode_reg ? S_LOAD : S_EMIT;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- rtl/triangle_vertex_normals.sv -----
// triangle_vertex_normals: top level, front queue plus normal engine.
// Depends on tvn_pkg, tvn_if, tvn_front, tvn_back (and tvn_div below it).
//
//  channel   dir  handshake          beat
//  tri_in    in   valid/ready        one triangle, nine coordinates
//  nrm_out   out  valid/ready        one vertex normal, three beats per triangle
//  cfg       in   cfg_we/cfg_wdata   smooth_mode, single register
//
// Steps: one pass normalises one vector: cross product (6 products on one multiplier)
//   or a load, the exponent steps, the squares, a 31-step square root, a load plus
//   NORMAL_FRAC_BITS+1 division steps on three lanes, and a clamp.
// Flat mode: one pass and three beats per triangle. Smooth mode: three passes, one per
//   vertex. A degenerate vector goes from the exponent step straight to the beats.
// The square root and the divider set the rate; nrm_out stalls slow it further.
// Reset: asynchronous, active low; queue empty, smooth_mode = 1, no beat pending.
// Stalls: a two-entry queue takes triangles while the back end works; the result
//   register lets a beat wait on nrm_out without stopping the front.
module triangle_vertex_normals #(
    parameter int COORD_BITS       = 24,
    parameter int NORMAL_FRAC_BITS = 14
) (
    input  logic       clk,
    input  logic       rst_n,
    tvn_tri_if.sink    tri_in,
    tvn_nrm_if.source  nrm_out,
    input  logic       cfg_we,
    input  logic       cfg_wdata
);

    logic signed [COORD_BITS-1:0] job_crd [9];
    tvn_pkg::tvn_job_t            job;
    logic                         job_take;

    // front: mode tagging and queue
    tvn_front #(.COORD_BITS(COORD_BITS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .tri_in    (tri_in),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .job_crd   (job_crd),
        .job       (job),
        .job_take  (job_take)
    );

    // back: arithmetic and result beats
    tvn_back #(
        .COORD_BITS       (COORD_BITS),
        .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .job_crd  (job_crd),
        .job      (job),
        .job_take (job_take),
        .nrm_out  (nrm_out)
    );

    // a triangle leaves the queue only once it is there
    a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
        job_take |-> job.valid)
        else $error("queue popped while empty");

    // a degenerate beat carries a zero normal
    a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (nrm_out.valid && nrm_out.degenerate) |->
        (nrm_out.nx == '0 && nrm_out.ny == '0 && nrm_out.nz == '0))
        else $error("degenerate beat with non-zero normal");

    // the queue is released only on the final beat of a triangle
    a_take_last: assert property (@(posedge clk) disable iff (!rst_n)
        job_take |=> (nrm_out.valid && nrm_out.last))
        else $error("triangle released before its last beat");

endmodule

// ----- tb/sv/tvn_normal_checker.sv -----
// tvn_normal_checker: watches the triangle and normal channels of triangle_vertex_normals,
// predicts every normal beat and compares it field by field.
// Depends on tvn_pkg and tvn_if.
module tvn_normal_checker (
    input  logic      clk,
    input  logic      rst_n,
    tvn_tri_if        tri_mon,
    tvn_nrm_if        nrm_mon,
    input  logic      cfg_we,
    input  logic      cfg_wdata,
    output int        fail_count,
    output int        normals_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [1:0]  vertex_index;
        logic [15:0] nx;
        logic [15:0] ny;
        logic [15:0] nz;
        logic        degenerate;
        logic        last;
    } normal_beat_t;

    normal_beat_t expected_normals[$];
    logic         smooth_mode;

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
        fail_count++;
    endtask

    function automatic int bit_length(input longint unsigned v);
        int n;
        n = 0;
        while (v != 0)
        begin
            n++;
            v >>= 1;
        end
        return n;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    // Block-floating scale to 30 significant bits, truncated length, rounded quotient.
    task automatic unit_vector(input longint signed c[3], output logic [15:0] n[3],
                               output logic deg);
        longint unsigned mag[3];
        longint unsigned m[3];
        longint unsigned sum;
        longint unsigned root;
        longint unsigned q;
        int len;
        len = 0;
        sum = 0;
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = (c[i] < 0) ? longint'(-c[i]) : c[i];
            if (bit_length(mag[i]) > len)
                len = bit_length(mag[i]);
        end
        deg = (len == 0);
        for (int i = 0; i < 3; i++)
            n[i] = '0;
        if (!deg)
        begin
            for (int i = 0; i < 3; i++)
            begin
                m[i] = (len > 30) ? mag[i] >> (len - 30) : mag[i] << (30 - len);
                sum += m[i] * m[i];
            end
            root = int_sqrt(sum);
            for (int i = 0; i < 3; i++)
            begin
                q = ((m[i] << 14) + (root >> 1)) / root;
                if (c[i] < 0)
                begin
                    if (q > 32768)
                        q = 32768;
                    n[i] = 16'(-q);
                end
                else
                begin
                    if (q > 32767)
                        q = 32767;
                    n[i] = 16'(q);
                end
            end
        end
    endtask

    task automatic predict_triangle();
        longint signed v[3][3];
        longint signed e1[3];
        longint signed e2[3];
        longint signed cr[3];
        logic [15:0]   n[3];
        logic          deg;
        normal_beat_t  beat;
        v[0][0] = tri_mon.ax;  v[0][1] = tri_mon.ay;       v[0][2] = tri_mon.az;
        v[1][0] = tri_mon.bx;  v[1][1] = tri_mon.by_coord; v[1][2] = tri_mon.bz;
        v[2][0] = tri_mon.cx;  v[2][1] = tri_mon.cy;       v[2][2] = tri_mon.cz;
        if (!smooth_mode)
        begin
            for (int j = 0; j < 3; j++)
            begin
                e1[j] = v[0][j] - v[1][j];
                e2[j] = v[1][j] - v[2][j];
            end
            cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
            cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
            cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
            unit_vector(cr, n, deg);
        end
        for (int k = 0; k < 3; k++)
        begin
            if (smooth_mode)
                unit_vector(v[k], n, deg);
            beat.vertex_index = 2'(k);
            beat.nx = n[0];
            beat.ny = n[1];
            beat.nz = n[2];
            beat.degenerate = deg;
            beat.last = (2'(k) == tvn_pkg::LAST_VERTEX);
            expected_normals.push_back(beat);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        normal_beat_t want;
        if (!rst_n)
        begin
            smooth_mode <= 1'b1;
            expected_normals.delete();
            normals_pending <= 0;
        end
        else
        begin
            if (nrm_mon.valid && nrm_mon.ready)
            begin
                if (expected_normals.size() == 0)
                begin
                    $display("%0t: normal beat with nothing expected", $realtime);
                    fail_count++;
                end
                else
                begin
                    want = expected_normals.pop_front();
                    if (nrm_mon.vertex_index !== want.vertex_index)
                        report_mismatch("vertex_index", 16'(nrm_mon.vertex_index),
                                        16'(want.vertex_index));
                    if (nrm_mon.nx !== want.nx)
                        report_mismatch("nx", nrm_mon.nx, want.nx);
                    if (nrm_mon.ny !== want.ny)
                        report_mismatch("ny", nrm_mon.ny, want.ny);
                    if (nrm_mon.nz !== want.nz)
                        report_mismatch("nz", nrm_mon.nz, want.nz);
                    if (nrm_mon.degenerate !== want.degenerate)
                        report_mismatch("degenerate", 16'(nrm_mon.degenerate),
                                        16'(want.degenerate));
                    if (nrm_mon.last !== want.last)
                        report_mismatch("last", 16'(nrm_mon.last), 16'(want.last));
                end
            end
            if (tri_mon.valid && tri_mon.ready)
                predict_triangle();
            if (cfg_we)
                smooth_mode <= cfg_wdata;
            normals_pending <= expected_normals.size();
        end
    end

    initial
        fail_count = 0;

endmodule

// ----- tb/sv/tb_triangle_vertex_normals.sv -----
// tb_triangle_vertex_normals: stimulus and verdict for triangle_vertex_normals.
// Depends on tvn_pkg, tvn_if, the block and tvn_normal_checker.
module tb_triangle_vertex_normals;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_PER_MODE = 80;
    localparam logic signed [23:0] COORD_MAX = 24'sd8388607;
    localparam logic signed [23:0] COORD_MIN = -24'sd8388608;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;
    int   fail_count;
    int   normals_pending;
    // idle percentages of each side, changed per phase
    int   send_idle_pct;
    int   recv_idle_pct;

    tvn_tri_if #(.COORD_BITS(24)) tri_if ();
    tvn_nrm_if                    nrm_if ();

    triangle_vertex_normals dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .tri_in    (tri_if),
        .nrm_out   (nrm_if),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    tvn_normal_checker normal_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .tri_mon         (tri_if),
        .nrm_mon         (nrm_if),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .fail_count      (fail_count),
        .normals_pending (normals_pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Receiver: ready drops at random per the current idle share.
    always @(posedge clk)
        nrm_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    // Hard stop well beyond the slowest legal run (three passes per smooth triangle
    // plus stalls on both sides).
    initial
    begin
        #20ms;
        $display("tb_triangle_vertex_normals failed");
        $finish;
    end

    // Coordinate mix: full range, small, extremes and zero.
    function automatic logic signed [23:0] rand_coord();
        case ($urandom_range(0, 9))
            0:       return COORD_MAX;
            1:       return COORD_MIN;
            2:       return '0;
            3, 4:    return 24'($signed($urandom_range(0, 511)) - 256);
            default: return 24'($urandom);
        endcase
    endfunction

    // One triangle beat; valid stays high after acceptance until the next beat
    // or an explicit drop, so back-to-back beats need no gap.
    task automatic send_triangle(input logic signed [23:0] c[9]);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            tri_if.valid <= 1'b0;
            @(posedge clk);
        end
        tri_if.valid    <= 1'b1;
        tri_if.ax       <= c[0];
        tri_if.ay       <= c[1];
        tri_if.az       <= c[2];
        tri_if.bx       <= c[3];
        tri_if.by_coord <= c[4];
        tri_if.bz       <= c[5];
        tri_if.cx       <= c[6];
        tri_if.cy       <= c[7];
        tri_if.cz       <= c[8];
        @(posedge clk);
        while (!tri_if.ready)
            @(posedge clk);
    endtask

    // Drop valid after the last beat and let the checker see it.
    task automatic stop_sending();
        tri_if.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_random_triangle();
        logic signed [23:0] c[9];
        int sel;
        for (int i = 0; i < 9; i++)
            c[i] = rand_coord();
        sel = $urandom_range(0, 9);
        // a few collinear or repeated vertices, so the flat normal collapses, or a vertex at the origin
        if (sel == 0)
        begin
            c[3] = c[0]; c[4] = c[1]; c[5] = c[2];
        end
        else if (sel == 1)
        begin
            for (int j = 0; j < 3; j++)
            begin
                c[j] = 24'($signed($urandom_range(0, 1023)) - 512);
                c[3 + j] = c[j] + 24'sd7 * 24'(j + 1);
                c[6 + j] = c[3 + j] + 24'sd7 * 24'(j + 1);
            end
        end
        else if (sel == 2)
        begin
            c[0] = '0; c[1] = '0; c[2] = '0;
        end
        send_triangle(c);
    endtask

    // Register writes only with the block drained.
    task automatic set_smooth_mode(input logic mode);
        stop_sending();
        wait (normals_pending == 0);
        repeat (250) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= mode;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic directed_triangles();
        logic signed [23:0] c[9];
        c = '{default: 24'sd0};
        send_triangle(c);                                   // zero vectors everywhere
        c = '{default: COORD_MAX};
        send_triangle(c);
        c = '{default: COORD_MIN};
        send_triangle(c);
        c = '{COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN,
              COORD_MIN, COORD_MIN, COORD_MAX};
        send_triangle(c);
        c = '{24'sd4096, '0, '0, '0, 24'sd4096, '0, '0, '0, 24'sd4096};  // axis unit vertices
        send_triangle(c);
        c = '{24'sd1, '0, '0, '0, -24'sd1, '0, '0, '0, 24'sd1};
        send_triangle(c);
        c = '{'0, '0, '0, 24'sd3, 24'sd4, '0, -24'sd5, 24'sd12, 24'sd0};
        send_triangle(c);
        c = '{24'sd1, 24'sd1, 24'sd1, 24'sd2, 24'sd2, 24'sd2, 24'sd3, 24'sd3, 24'sd3};
        send_triangle(c);                                   // collinear
        c = '{COORD_MAX, '0, '0, COORD_MIN, '0, '0, '0, COORD_MAX, COORD_MIN};
        send_triangle(c);
        c = '{-24'sd1, -24'sd1, -24'sd1, COORD_MAX, COORD_MAX, 24'sd1,
              COORD_MIN, 24'sd1, COORD_MAX};
        send_triangle(c);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = 1'b0;
        send_idle_pct = 26;
        recv_idle_pct = 46;
        tri_if.valid  = 1'b0;
        tri_if.ax = '0; tri_if.ay = '0; tri_if.az = '0;
        tri_if.bx = '0; tri_if.by_coord = '0; tri_if.bz = '0;
        tri_if.cx = '0; tri_if.cy = '0; tri_if.cz = '0;
        nrm_if.ready  = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // smooth mode out of reset, then flat, both directed
        directed_triangles();
        set_smooth_mode(1'b0);
        directed_triangles();

        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 26 : (ph == 1) ? 46 : 0;
            recv_idle_pct = (ph == 0) ? 46 : (ph == 1) ? 26 : 0;
            set_smooth_mode(1'b1);
            repeat (RANDOM_PER_MODE) send_random_triangle();
            set_smooth_mode(1'b0);
            repeat (RANDOM_PER_MODE) send_random_triangle();
        end

        stop_sending();
        wait (normals_pending == 0);
        repeat (300) @(posedge clk);
        if (fail_count == 0)
            $display("tb_triangle_vertex_normals passed");
        else
            $display("tb_triangle_vertex_normals failed");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/tvn_pkg.sv
rtl/tvn_if.sv
rtl/tvn_front.sv
rtl/tvn_div.sv
rtl/tvn_back.sv
rtl/triangle_vertex_normals.sv
tb/sv/tvn_normal_checker.sv
tb/sv/tb_triangle_vertex_normals.sv
